>>> rtl/assert_macros.svh
// Assertion macros shared by the PI motor controller RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PMC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pmc_pkg.sv
// Package for the PI motor controller: widths, constants, types and helpers.
// No dependencies.
package pmc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ANGLE_W   = 32 + FRAC_BITS;
    localparam int PROP_W    = 64 - FRAC_BITS;
    localparam int IMAG_W    = 64 - FRAC_BITS;
    localparam int MICROS_W  = 20;
    localparam int QUOT_W    = 36;
    localparam int NUM_W     = (ANGLE_W + MICROS_W > IMAG_W + 32) ?
                               (ANGLE_W + MICROS_W) : (IMAG_W + 32);
    localparam int HALF_A    = (ANGLE_W + 1) / 2;
    localparam int HALF_I    = (IMAG_W + 1) / 2;
    localparam int CFG_INDEX_W = 3;

    // reciprocal divide by 100 or 10^6: numerator below 2^RCP_N, exact floor
    localparam int RCP_N       = 54;
    localparam int RCP_M_W     = 55;
    localparam int RCP_XH      = RCP_N / 2;
    localparam int RCP_ML      = RCP_M_W - RCP_XH;
    localparam int RCP_P_W     = RCP_N + RCP_M_W;
    localparam int RCP_SH_FILT = RCP_N + 7;
    localparam int RCP_SH_INC  = RCP_N + 20;

    localparam logic [MICROS_W-1:0] MICROS_PER_S   = 20'd1000000;
    localparam logic [31:0]         DEG_TO_RAD_Q32 = 32'd74961321;
    localparam logic [QUOT_W-1:0]   VEL_CAP        = QUOT_W'(1) << 31;
    localparam logic [QUOT_W-1:0]   INC_CAP        = QUOT_W'(1) << 34;
    localparam logic [RCP_M_W-1:0]  RCP_M_FILT     = 55'd23058430092136940;
    localparam logic [RCP_M_W-1:0]  RCP_M_INC      = 55'd18889465931478581;

    localparam logic        RST_MODE     = 1'b0;
    localparam logic [30:0] RST_GAIN     = 31'd65536;
    localparam logic [30:0] RST_IGAIN    = 31'd32768;
    localparam logic [30:0] RST_LIMIT    = 31'd65536;
    localparam logic [19:0] RST_PERIOD   = 20'd1000;
    localparam logic [31:0] RST_SETPOINT = 32'd0;
    localparam logic [31:0] RST_RPC      = 32'd6588397;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MODE,
        REG_GAIN,
        REG_IGAIN,
        REG_LIMIT,
        REG_PERIOD,
        REG_SETPOINT,
        REG_RPC
    } pmc_reg_t;

    typedef struct packed {
        logic        mode;
        logic [30:0] gain;
        logic [30:0] integral_gain;
        logic [30:0] limit;
        logic [19:0] loop_period_us;
        logic [31:0] setpoint;
        logic [31:0] radians_per_count;
    } pmc_cfg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_ANGLE,
        S_VDIFF,
        S_VMUL_LO,
        S_VMUL_HI,
        S_VDIV,
        S_VDIV_WAIT,
        S_VEST,
        S_VFNUM,
        S_FDIV,
        S_FDIV_WAIT,
        S_VFILT,
        S_PTARGET,
        S_PERR,
        S_PROP,
        S_IMAG,
        S_IMUL_LO,
        S_IMUL_HI,
        S_IDIV,
        S_IDIV_WAIT,
        S_ISUM,
        S_FINISH
    } pmc_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ANGLE,
        OP_VDIFF,
        OP_VMUL_LO,
        OP_VMUL_HI,
        OP_DIV_VEL,
        OP_VEST,
        OP_VFNUM,
        OP_DIV_FILT,
        OP_VFILT,
        OP_PTARGET,
        OP_PERR,
        OP_PROP,
        OP_IMAG,
        OP_IMUL_LO,
        OP_IMUL_HI,
        OP_DIV_INC,
        OP_ISUM,
        OP_FINISH
    } pmc_op_t;

    typedef struct packed {
        pmc_op_t op;
    } pmc_cmd_t;

    typedef struct packed {
        logic trigger;
        logic velocity_mode;
        logic div_busy;
        logic out_free;
    } pmc_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (x < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_lim(input logic signed [63:0] x,
                                                     input logic [30:0] lim);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        logic signed [31:0] r;
        hi = $signed({33'd0, lim});
        lo = -hi;
        if (x > hi)
            r = hi[31:0];
        else if (x < lo)
            r = lo[31:0];
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

>>> rtl/pmc_cfg.sv
// Configuration register bank of the PI motor controller.
// Depends on pmc_pkg.
module pmc_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                        cfg_data,
    output pmc_pkg::pmc_cfg_t                  cfg
);
    import pmc_pkg::*;

    pmc_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode              <= RST_MODE;
            cfg_reg.gain              <= RST_GAIN;
            cfg_reg.integral_gain     <= RST_IGAIN;
            cfg_reg.limit             <= RST_LIMIT;
            cfg_reg.loop_period_us    <= RST_PERIOD;
            cfg_reg.setpoint          <= RST_SETPOINT;
            cfg_reg.radians_per_count <= RST_RPC;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (pmc_reg_t'(cfg_index))
                REG_MODE:     cfg_reg.mode              <= cfg_data[0];
                REG_GAIN:     cfg_reg.gain              <= cfg_data[30:0];
                REG_IGAIN:    cfg_reg.integral_gain     <= cfg_data[30:0];
                REG_LIMIT:    cfg_reg.limit             <= cfg_data[30:0];
                REG_PERIOD:   cfg_reg.loop_period_us    <= cfg_data[19:0];
                REG_SETPOINT: cfg_reg.setpoint          <= cfg_data;
                REG_RPC:      cfg_reg.radians_per_count <= cfg_data;
                default:      ;
            endcase
        end
    end

endmodule

>>> rtl/pmc_div.sv
// Restoring divider, one quotient bit per cycle, saturating quotient; and a
// reciprocal-multiply divide by 100 or 10^6. Depends on pmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pmc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pmc_pkg::NUM_W-1:0]     num,
    input  logic [31:0]                   den,
    output logic                          busy,
    output logic [pmc_pkg::QUOT_W-1:0]    quot
);
    import pmc_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);

    logic              busy_reg;
    logic              ovf_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [31:0]       rem_reg;
    logic [31:0]       den_reg;
    logic [QUOT_W-1:0] nlo_reg;

    logic [32:0] trial;
    logic [32:0] trial_diff;
    logic        fits;
    logic        overflow;

    assign trial      = {rem_reg, nlo_reg[QUOT_W-1]};
    assign fits       = trial >= {1'b0, den_reg};
    assign trial_diff = trial - {1'b0, den_reg};
    assign overflow   = num[NUM_W-1:QUOT_W] >= (NUM_W - QUOT_W)'(den);

    assign busy = busy_reg;
    assign quot = ovf_reg ? {QUOT_W{1'b1}} : nlo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= !overflow;
            ovf_reg  <= overflow;
            cnt_reg  <= CNT_LAST;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= num[QUOT_W+31:QUOT_W];
            nlo_reg <= num[QUOT_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial_diff[31:0] : trial[31:0];
            nlo_reg <= {nlo_reg[QUOT_W-2:0], fits};
        end
    end

    `PMC_ASSERT_NEXT(a_div_ends, busy_reg && !start && cnt_reg == '0, !busy_reg, "divider overran")
    `PMC_ASSERT_NEXT(a_div_starts, start && !overflow, busy_reg && cnt_reg == CNT_LAST, "divider did not start")

endmodule

// Four partial products, one per cycle; sel picks 10^6 over 100.
module pmc_recip (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          sel,
    input  logic [pmc_pkg::RCP_N-1:0]     num,
    output logic                          busy,
    output logic [pmc_pkg::QUOT_W-1:0]    quot
);
    import pmc_pkg::*;

    localparam logic [1:0] STEP_LAST = 2'd3;

    logic                     busy_reg;
    logic                     sel_reg;
    logic [1:0]               step_reg;
    logic [RCP_N-1:0]         num_reg;
    logic [RCP_P_W-1:0]       acc_reg;

    logic [RCP_M_W-1:0]       recip;
    logic [RCP_XH-1:0]        xa;
    logic [RCP_ML-1:0]        mb;
    logic [RCP_XH+RCP_ML-1:0] pp;
    logic [RCP_P_W-1:0]       pp_sh;

    assign recip = sel_reg ? RCP_M_INC : RCP_M_FILT;
    assign xa    = step_reg[1] ? num_reg[RCP_N-1:RCP_XH] : num_reg[RCP_XH-1:0];
    assign mb    = step_reg[0] ? RCP_ML'(recip[RCP_M_W-1:RCP_ML]) : recip[RCP_ML-1:0];
    assign pp    = xa * mb;
    assign busy  = busy_reg;
    assign quot  = sel_reg ? QUOT_W'(acc_reg[RCP_P_W-1:RCP_SH_INC])
                           : acc_reg[RCP_SH_FILT+QUOT_W-1:RCP_SH_FILT];

    always_comb
    begin
        case (step_reg)
            2'd0:    pp_sh = RCP_P_W'(pp);
            2'd1:    pp_sh = RCP_P_W'(pp) << RCP_ML;
            2'd2:    pp_sh = RCP_P_W'(pp) << RCP_XH;
            default: pp_sh = RCP_P_W'(pp) << (RCP_XH + RCP_ML);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_LAST)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sel_reg <= sel;
            num_reg <= num;
            acc_reg <= '0;
        end
        else if (busy_reg)
            acc_reg <= acc_reg + pp_sh;
    end

    `PMC_ASSERT_NEXT(a_rcp_ends, busy_reg && !start && step_reg == STEP_LAST, !busy_reg, "reciprocal divide overran")

endmodule

>>> rtl/pmc_datapath.sv
// Datapath of the PI motor controller: state, work registers, multipliers,
// result register. Depends on pmc_pkg, pmc_div, pmc_recip and assert_macros.svh.
`include "assert_macros.svh"

module pmc_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pmc_pkg::pmc_cmd_t         cmd,
    output pmc_pkg::pmc_stat_t        stat,
    input  pmc_pkg::pmc_cfg_t         cfg,
    input  logic [31:0]               now_us,
    input  logic signed [31:0]        encoder_count,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      direction,
    output logic [7:0]                duty,
    output logic signed [31:0]        drive,
    output logic signed [31:0]        measured
);
    import pmc_pkg::*;

    logic [31:0]               now_reg;
    logic signed [31:0]        count_reg;
    logic [31:0]               elapsed_reg;
    logic                      trigger_reg;
    logic [31:0]               last_time_reg;
    logic signed [ANGLE_W-1:0] last_angle_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic signed [31:0]        filt_reg;
    logic signed [31:0]        integ_reg;
    logic signed [31:0]        last_err_reg;
    logic [ANGLE_W-1:0]        dmag_reg;
    logic                      dneg_reg;
    logic [NUM_W-1:0]          acc_reg;
    logic signed [31:0]        est_reg;
    logic                      fneg_reg;
    logic signed [31:0]        err_reg;
    logic signed [31:0]        meas_reg;
    logic signed [31:0]        target_reg;
    logic signed [31:0]        integ_new_reg;
    logic signed [PROP_W-1:0]  prop_reg;
    logic [32:0]               smag_reg;
    logic                      sneg_reg;
    logic [IMAG_W-1:0]         imag_reg;
    logic                      out_valid_reg;
    logic                      direction_reg;
    logic [7:0]                duty_reg;
    logic signed [31:0]        drive_reg;
    logic signed [31:0]        measured_reg;

    logic [31:0]                          elapsed_now;
    logic signed [63:0]                   angle_prod;
    logic signed [ANGLE_W:0]              diff;
    logic [HALF_A+MICROS_W-1:0]           vlo_p;
    logic [ANGLE_W-HALF_A+MICROS_W-1:0]   vhi_p;
    logic [HALF_I+31:0]                   ilo_p;
    logic [IMAG_W-HALF_I+31:0]            ihi_p;
    logic signed [31:0]                   est_val;
    logic signed [39:0]                   fnum;
    logic [39:0]                          fmag;
    logic signed [31:0]                   newfilt;
    logic signed [63:0]                   tprod;
    logic signed [63:0]                   pprod;
    logic signed [32:0]                   ssum;
    logic [63:0]                          iprod;
    logic [QUOT_W-1:0]                    inc_mag;
    logic signed [QUOT_W:0]               inc;
    logic signed [63:0]                   isum;
    logic signed [63:0]                   dsum;
    logic signed [31:0]                   drv;
    logic [30:0]                          dabs;
    logic [38:0]                          dscaled;
    logic [38:0]                          dshift;
    logic                                 div_start;
    logic                                 div_busy;
    logic [QUOT_W-1:0]                    quot;
    logic                                 rcp_start;
    logic                                 rcp_sel;
    logic                                 rcp_busy;
    logic [QUOT_W-1:0]                    rquot;

    assign elapsed_now = now_us - last_time_reg;
    assign angle_prod  = count_reg * $signed({1'b0, cfg.radians_per_count});
    assign diff        = $signed({angle_reg[ANGLE_W-1], angle_reg})
                       - $signed({last_angle_reg[ANGLE_W-1], last_angle_reg});
    assign vlo_p       = dmag_reg[HALF_A-1:0] * MICROS_PER_S;
    assign vhi_p       = dmag_reg[ANGLE_W-1:HALF_A] * MICROS_PER_S;
    assign ilo_p       = imag_reg[HALF_I-1:0] * elapsed_reg;
    assign ihi_p       = imag_reg[IMAG_W-1:HALF_I] * elapsed_reg;
    assign fnum        = 40'sd98 * filt_reg + 40'sd2 * est_reg;
    assign fmag        = fnum[39] ? unsigned'(-fnum) : unsigned'(fnum);
    assign newfilt     = fneg_reg ? -$signed(rquot[31:0]) : $signed(rquot[31:0]);
    assign tprod       = $signed(cfg.setpoint) * $signed({1'b0, DEG_TO_RAD_Q32});
    assign pprod       = err_reg * $signed({1'b0, cfg.gain});
    assign ssum        = 33'(err_reg) + 33'(last_err_reg);
    assign iprod       = cfg.integral_gain * smag_reg;
    assign inc_mag     = (acc_reg[NUM_W-1:RCP_N] != '0 || rquot > INC_CAP) ? INC_CAP : rquot;
    assign inc         = sneg_reg ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});
    assign isum        = 64'(integ_reg) + 64'(inc);
    assign dsum        = 64'(prop_reg) + 64'(integ_new_reg);
    assign drv         = clamp_lim(dsum, cfg.limit);
    assign dabs        = drv[31] ? 31'(-drv) : drv[30:0];
    assign dscaled     = {dabs, 8'd0} - 39'(dabs);
    assign dshift      = dscaled >> FRAC_BITS;

    always_comb
    begin
        if (dneg_reg)
            est_val = (quot >= VEL_CAP) ? 32'sh8000_0000 : -$signed(quot[31:0]);
        else
            est_val = (quot >= VEL_CAP) ? 32'sh7FFF_FFFF : $signed(quot[31:0]);
    end

    always_comb
    begin
        div_start = 1'b0;
        rcp_start = 1'b0;
        rcp_sel   = 1'b0;
        case (cmd.op)
            OP_DIV_VEL:
                div_start = 1'b1;
            OP_DIV_FILT:
                rcp_start = 1'b1;
            OP_DIV_INC:
            begin
                rcp_start = 1'b1;
                rcp_sel   = 1'b1;
            end
            default: ;
        endcase
    end

    pmc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_reg),
        .den   (elapsed_reg),
        .busy  (div_busy),
        .quot  (quot)
    );

    pmc_recip u_recip (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rcp_start),
        .sel   (rcp_sel),
        .num   (acc_reg[RCP_N-1:0]),
        .busy  (rcp_busy),
        .quot  (rquot)
    );

    assign stat.trigger       = trigger_reg;
    assign stat.velocity_mode = cfg.mode;
    assign stat.div_busy      = div_busy || rcp_busy;
    assign stat.out_free      = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign direction = direction_reg;
    assign duty      = duty_reg;
    assign drive     = drive_reg;
    assign measured  = measured_reg;

    // controller state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg  <= '0;
            last_angle_reg <= '0;
            filt_reg       <= '0;
            integ_reg      <= '0;
            last_err_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && cmd.op != OP_FINISH)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                OP_VFILT:
                    filt_reg <= newfilt;
                OP_FINISH:
                begin
                    last_time_reg  <= now_reg;
                    last_angle_reg <= angle_reg;
                    integ_reg      <= integ_new_reg;
                    last_err_reg   <= err_reg;
                    out_valid_reg  <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                now_reg     <= now_us;
                count_reg   <= encoder_count;
                elapsed_reg <= elapsed_now;
                trigger_reg <= elapsed_now > 32'(cfg.loop_period_us);
            end
            OP_ANGLE:
                angle_reg <= angle_prod[63:32-FRAC_BITS];
            OP_VDIFF:
            begin
                dneg_reg <= diff[ANGLE_W];
                dmag_reg <= diff[ANGLE_W] ? ANGLE_W'(-diff) : diff[ANGLE_W-1:0];
            end
            OP_VMUL_LO:
                acc_reg <= NUM_W'(vlo_p);
            OP_VMUL_HI:
                acc_reg <= acc_reg + (NUM_W'(vhi_p) << HALF_A);
            OP_VEST:
                est_reg <= est_val;
            OP_VFNUM:
            begin
                fneg_reg <= fnum[39];
                acc_reg  <= NUM_W'(fmag);
            end
            OP_VFILT:
            begin
                err_reg  <= sat32(64'($signed(cfg.setpoint)) - 64'(newfilt));
                meas_reg <= newfilt;
            end
            OP_PTARGET:
                target_reg <= tprod[63:32];
            OP_PERR:
            begin
                err_reg  <= sat32(64'(target_reg) - 64'(angle_reg));
                meas_reg <= sat32(64'(angle_reg));
            end
            OP_PROP:
            begin
                prop_reg <= pprod[63:FRAC_BITS];
                sneg_reg <= ssum[32];
                smag_reg <= ssum[32] ? unsigned'(-ssum) : unsigned'(ssum);
            end
            OP_IMAG:
                imag_reg <= iprod[63:FRAC_BITS];
            OP_IMUL_LO:
                acc_reg <= NUM_W'(ilo_p);
            OP_IMUL_HI:
                acc_reg <= acc_reg + (NUM_W'(ihi_p) << HALF_I);
            OP_ISUM:
                integ_new_reg <= clamp_lim(isum, cfg.limit);
            OP_FINISH:
            begin
                direction_reg <= !(drv > 32'sd0);
                duty_reg      <= (dshift > 39'd255) ? 8'd255 : dshift[7:0];
                drive_reg     <= drv;
                measured_reg  <= meas_reg;
            end
            default: ;
        endcase
    end

    `PMC_ASSERT_NEXT(a_finish_commit, cmd.op == OP_FINISH, out_valid_reg && last_time_reg == $past(now_reg), "result not committed")

endmodule

>>> rtl/pmc_ctrl.sv
// Controller state machine of the PI motor controller: sequences datapath ops.
// Depends on pmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pmc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pmc_pkg::pmc_stat_t    stat,
    output pmc_pkg::pmc_cmd_t     cmd
);
    import pmc_pkg::*;

    pmc_state_t state_reg;
    pmc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
                state_next = stat.trigger ? S_ANGLE : S_IDLE;
            S_ANGLE:
            begin
                cmd.op     = OP_ANGLE;
                state_next = stat.velocity_mode ? S_VDIFF : S_PTARGET;
            end
            S_VDIFF:
            begin
                cmd.op     = OP_VDIFF;
                state_next = S_VMUL_LO;
            end
            S_VMUL_LO:
            begin
                cmd.op     = OP_VMUL_LO;
                state_next = S_VMUL_HI;
            end
            S_VMUL_HI:
            begin
                cmd.op     = OP_VMUL_HI;
                state_next = S_VDIV;
            end
            S_VDIV:
            begin
                cmd.op     = OP_DIV_VEL;
                state_next = S_VDIV_WAIT;
            end
            S_VDIV_WAIT:
                if (!stat.div_busy)
                    state_next = S_VEST;
            S_VEST:
            begin
                cmd.op     = OP_VEST;
                state_next = S_VFNUM;
            end
            S_VFNUM:
            begin
                cmd.op     = OP_VFNUM;
                state_next = S_FDIV;
            end
            S_FDIV:
            begin
                cmd.op     = OP_DIV_FILT;
                state_next = S_FDIV_WAIT;
            end
            S_FDIV_WAIT:
                if (!stat.div_busy)
                    state_next = S_VFILT;
            S_VFILT:
            begin
                cmd.op     = OP_VFILT;
                state_next = S_PROP;
            end
            S_PTARGET:
            begin
                cmd.op     = OP_PTARGET;
                state_next = S_PERR;
            end
            S_PERR:
            begin
                cmd.op     = OP_PERR;
                state_next = S_PROP;
            end
            S_PROP:
            begin
                cmd.op     = OP_PROP;
                state_next = S_IMAG;
            end
            S_IMAG:
            begin
                cmd.op     = OP_IMAG;
                state_next = S_IMUL_LO;
            end
            S_IMUL_LO:
            begin
                cmd.op     = OP_IMUL_LO;
                state_next = S_IMUL_HI;
            end
            S_IMUL_HI:
            begin
                cmd.op     = OP_IMUL_HI;
                state_next = S_IDIV;
            end
            S_IDIV:
            begin
                cmd.op     = OP_DIV_INC;
                state_next = S_IDIV_WAIT;
            end
            S_IDIV_WAIT:
                if (!stat.div_busy)
                    state_next = S_ISUM;
            S_ISUM:
            begin
                cmd.op     = OP_ISUM;
                state_next = S_FINISH;
            end
            S_FINISH:
                if (stat.out_free)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    `PMC_ASSERT_IMP(a_div_in_wait, stat.div_busy, state_reg == S_VDIV_WAIT || state_reg == S_FDIV_WAIT || state_reg == S_IDIV_WAIT, "divider busy outside a wait state")

endmodule

>>> rtl/pi_motor_controller_tustin_core.sv
// Top level of the PI motor controller with Tustin integral and anti-windup.
// Depends on pmc_pkg, pmc_cfg, pmc_ctrl and pmc_datapath.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  in       | in_valid / in_stall     | now_us, encoder_count
//  out      | out_valid / out_stall   | direction, duty, drive, measured
//  cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A tick that does not start a control step goes from S_IDLE through S_CHECK back to S_IDLE.
// A control step in either mode can wait at its end for the previous result to leave;
// the velocity divide ends early when its quotient overflows.
// The input is taken only while idle; a finished result waits in the output register.
// Reset is asynchronous and clears all controller state; no clearing pass.
module pi_motor_controller_tustin_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [31:0]                      now_us,
    input  logic signed [31:0]               encoder_count,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             direction,
    output logic [7:0]                       duty,
    output logic signed [31:0]               drive,
    output logic signed [31:0]               measured,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [31:0]                      cfg_data
);
    import pmc_pkg::*;

    pmc_cfg_t  cfg;
    pmc_cmd_t  cmd;
    pmc_stat_t stat;

    pmc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    pmc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg           (cfg),
        .now_us        (now_us),
        .encoder_count (encoder_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .direction     (direction),
        .duty          (duty),
        .drive         (drive),
        .measured      (measured)
    );

endmodule
